// ----- rtl/core/ole_pkg.sv -----
// Shared types and codes for the ordered list engine.
// Holds the input and result word structs, operation and status codes, and default sizes.
// Depends on nothing.
package ole_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int HANDLE_BITS_DEF = 32;
    localparam int LEN_BITS        = 7;

    localparam logic [3:0] MODE_PUSH_BACK  = 4'd0;
    localparam logic [3:0] MODE_PUSH_FRONT = 4'd1;
    localparam logic [3:0] MODE_POP_BACK   = 4'd2;
    localparam logic [3:0] MODE_POP_FRONT  = 4'd3;
    localparam logic [3:0] MODE_POP_AT     = 4'd4;
    localparam logic [3:0] MODE_REMOVE     = 4'd5;
    localparam logic [3:0] MODE_PEEK       = 4'd6;
    localparam logic [3:0] MODE_SPLICE     = 4'd7;
    localparam logic [3:0] MODE_CLEAR      = 4'd8;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_RANGE    = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [3:0]          mode;
        logic [31:0]         value;
        logic [LEN_BITS-1:0] position;
        logic [LEN_BITS-1:0] run_length;
    } in_word_t;

    typedef struct packed {
        logic [31:0]         item_value;
        logic [1:0]          status;
        logic [LEN_BITS-1:0] length_after;
        logic                last;
    } out_word_t;

endpackage

// ----- rtl/core/ole_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// Read data holds while no read is issued. Depends on nothing.
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/ordered_list_engine.sv -----
// Top level of the ordered list engine: sequencer, list pointers and output register.
// Depends on ole_pkg and ole_ram.
//
// The engine keeps up to DEPTH handles in a ring held in one RAM and takes one word at a
// time. A push, clear or rejected operation goes from idle straight to the output state;
// a pop or peek first reads the RAM. A pop at a position or a removal by value closes the
// gap by moving each later entry one place, one entry per cycle through the single read
// port of the RAM, after its result word is sent; a removal by value first scans from
// the front at one entry per cycle. A splice reads and sends each result word in turn
// and then moves the entries behind the run. The next word is taken while the last
// result word still waits in the output register.
module ordered_list_engine #(
    parameter int DEPTH       = ole_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = ole_pkg::HANDLE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ole_pkg::in_word_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ole_pkg::out_word_t m_data
);

    import ole_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_OUT  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_MOVE = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       occ_reg, occ_next;
    logic [IDX_W-1:0]       front_reg, front_next;
    logic [3:0]             op_reg, op_next;
    logic [HANDLE_BITS-1:0] val_reg, val_next;
    logic [CNT_W-1:0]       start_reg, start_next;
    logic [CNT_W-1:0]       gap_reg, gap_next;
    logic [CNT_W-1:0]       j_reg, j_next;
    logic                   move_reg, move_next;
    logic                   use_rd_reg, use_rd_next;
    logic [31:0]            item_reg, item_next;
    logic [1:0]             status_reg, status_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   pend_reg, pend_next;
    logic [CNT_W-1:0]       wr_idx_reg, wr_idx_next;
    logic                   m_valid_reg, m_valid_next;
    out_word_t              m_data_reg, m_data_next;

    logic                   ram_we, ram_re;
    logic [IDX_W-1:0]       ram_waddr, ram_raddr;
    logic [HANDLE_BITS-1:0] ram_wdata, ram_rdata;

    logic                   out_free, last_word;
    logic [63:0]            in_val64;
    logic [HANDLE_BITS-1:0] in_val;
    logic [7:0]             pos8, run8, occ8, avail8, cnt8;
    logic [IDX_W-1:0]       front_dec, front_inc;

    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] front,
                                              input logic [CNT_W-1:0] idx);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(front) + (CNT_W+1)'(idx);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [31:0] to_item(input logic [HANDLE_BITS-1:0] h);
        logic [63:0] wide;
        wide = 64'(h);
        return wide[31:0];
    endfunction

    ole_ram #(
        .WIDTH(HANDLE_BITS),
        .DEPTH(DEPTH)
    ) u_slots (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign in_val64  = 64'(s_data.value);
    assign in_val    = in_val64[HANDLE_BITS-1:0];
    assign pos8      = {1'b0, s_data.position};
    assign run8      = {1'b0, s_data.run_length};
    assign occ8      = 8'(occ_reg);
    assign avail8    = occ8 - pos8;
    assign cnt8      = (run8 < avail8) ? run8 : avail8;
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign last_word = !((op_reg == MODE_SPLICE) && use_rd_reg &&
                         (j_reg + 1'b1 != gap_reg));

    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        front_next   = front_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        start_next   = start_reg;
        gap_next     = gap_reg;
        j_next       = j_reg;
        move_next    = move_reg;
        use_rd_next  = use_rd_reg;
        item_next    = item_reg;
        status_next  = status_reg;
        rd_idx_next  = rd_idx_reg;
        pend_next    = pend_reg;
        wr_idx_next  = wr_idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = s_data.mode;
                    val_next    = in_val;
                    gap_next    = '0;
                    j_next      = '0;
                    move_next   = 1'b0;
                    use_rd_next = 1'b0;
                    item_next   = '0;
                    status_next = STAT_OK;
                    state_next  = S_OUT;
                    case (s_data.mode)
                        MODE_PUSH_BACK: begin
                            if (occ_reg == CNT_W'(DEPTH)) begin
                                status_next = STAT_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = phys(front_reg, occ_reg);
                                ram_wdata = in_val;
                                occ_next  = occ_reg + 1'b1;
                            end
                        end
                        MODE_PUSH_FRONT: begin
                            if (occ_reg == CNT_W'(DEPTH)) begin
                                status_next = STAT_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = front_dec;
                                ram_wdata  = in_val;
                                front_next = front_dec;
                                occ_next   = occ_reg + 1'b1;
                            end
                        end
                        MODE_POP_BACK, MODE_POP_FRONT: begin
                            if (occ_reg == '0) begin
                                status_next = STAT_RANGE;
                            end else begin
                                start_next  = (s_data.mode == MODE_POP_BACK) ?
                                              occ_reg - 1'b1 : '0;
                                gap_next    = CNT_W'(1);
                                use_rd_next = 1'b1;
                                state_next  = S_RD;
                            end
                        end
                        MODE_POP_AT, MODE_PEEK: begin
                            if (pos8 >= occ8) begin
                                status_next = STAT_RANGE;
                            end else begin
                                start_next  = CNT_W'(s_data.position);
                                use_rd_next = 1'b1;
                                state_next  = S_RD;
                                if (s_data.mode == MODE_POP_AT) begin
                                    gap_next  = CNT_W'(1);
                                    move_next = 1'b1;
                                end
                            end
                        end
                        MODE_REMOVE: begin
                            status_next = STAT_NOTFOUND;
                            rd_idx_next = '0;
                            pend_next   = 1'b0;
                            state_next  = S_SCAN;
                        end
                        MODE_SPLICE: begin
                            if ((run8 == '0) || (pos8 >= occ8)) begin
                                status_next = STAT_RANGE;
                            end else begin
                                start_next  = CNT_W'(s_data.position);
                                gap_next    = CNT_W'(cnt8);
                                move_next   = 1'b1;
                                use_rd_next = 1'b1;
                                state_next  = S_RD;
                            end
                        end
                        MODE_CLEAR: begin
                            occ_next   = '0;
                            front_next = '0;
                        end
                        default: begin
                            status_next = STAT_RANGE;
                        end
                    endcase
                end
            end
            S_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = phys(front_reg, CNT_W'(start_reg + j_reg));
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.item_value   = use_rd_reg ? to_item(ram_rdata) : item_reg;
                    m_data_next.status       = status_reg;
                    m_data_next.length_after = LEN_BITS'(occ_reg - gap_reg);
                    m_data_next.last         = last_word;
                    if (!last_word) begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_RD;
                    end else if (move_reg) begin
                        rd_idx_next = start_reg + gap_reg;
                        pend_next   = 1'b0;
                        state_next  = S_MOVE;
                    end else begin
                        occ_next = occ_reg - gap_reg;
                        if ((op_reg == MODE_POP_FRONT) && (gap_reg != '0)) begin
                            front_next = front_inc;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                if (pend_reg && (ram_rdata == val_reg)) begin
                    item_next   = to_item(val_reg);
                    status_next = STAT_OK;
                    start_next  = wr_idx_reg;
                    gap_next    = CNT_W'(1);
                    move_next   = 1'b1;
                    state_next  = S_OUT;
                end else if (rd_idx_reg < occ_reg) begin
                    ram_re      = 1'b1;
                    ram_raddr   = phys(front_reg, rd_idx_reg);
                    pend_next   = 1'b1;
                    wr_idx_next = rd_idx_reg;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end else if (pend_reg) begin
                    pend_next = 1'b0;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_MOVE: begin
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = phys(front_reg, wr_idx_reg);
                    ram_wdata = ram_rdata;
                end
                if (rd_idx_reg < occ_reg) begin
                    ram_re      = 1'b1;
                    ram_raddr   = phys(front_reg, rd_idx_reg);
                    pend_next   = 1'b1;
                    wr_idx_next = rd_idx_reg - gap_reg;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        occ_next   = occ_reg - gap_reg;
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            front_reg   <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            front_reg   <= front_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        start_reg  <= start_next;
        gap_reg    <= gap_next;
        j_reg      <= j_next;
        move_reg   <= move_next;
        use_rd_reg <= use_rd_next;
        item_reg   <= item_next;
        status_reg <= status_next;
        rd_idx_reg <= rd_idx_next;
        wr_idx_reg <= wr_idx_next;
        m_data_reg <= m_data_next;
    end

endmodule
